### hw/rtl/mmrc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmrc_pkg: shared types and constants of the region carver
// function codes, status codes, request and response records and the table entry record
// ---------------------------------------------------------------------------
package mmrc_pkg;

  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_APPEND = 3'd1,
    FUNC_CARVE  = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_SUM    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ENTRY = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  localparam logic [63:0] LOW_LIMIT = 64'h0000_0000_0010_0000;
  localparam int ENTRY_W = 144;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [15:0] kind;
  } entry_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [15:0] region_type;
    logic [7:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_base;
    logic [63:0] entry_length;
    logic [15:0] read_kind;
    logic [63:0] lower_total;
    logic [63:0] upper_total;
    logic [8:0]  table_count;
  } rsp_t;

endpackage

### hw/rtl/mmrc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmrc_if: valid/ready channel interfaces
// request, response and configuration channels
// ---------------------------------------------------------------------------
interface mmrc_req_if;
  logic           valid;
  logic           ready;
  mmrc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mmrc_rsp_if;
  logic           valid;
  logic           ready;
  mmrc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mmrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/mmrc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmrc_ram: generic single-port ram
// one access per cycle: a read and an optional write to the same address, registered read data
// ---------------------------------------------------------------------------
module mmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // optional write, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/memory_map_region_carver_unit.sv
`timescale 1ns / 1ps
// Sequencing: clear, unknown func, out-of-range read and append to a full table go
// straight to the result; append writes one entry, read fetches one, summarize reads
// every entry; carve scans until an entry holds the region, then shifts later entries
// up and inserts at most two; all table accesses share the single ram port.
// Throughput: one beat at a time; the next is taken once the result is taken.
// Reset: entry count cleared, usable type set to 1; table contents undefined.
// ---------------------------------------------------------------------------
// memory_map_region_carver_unit: ordered memory region table
// clear, append, carve, read and summarize; table accesses go through one sequenced ram port
// ---------------------------------------------------------------------------
module memory_map_region_carver_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic   clk,
  input  logic   rst_n,
  mmrc_req_if.sink   in_ch,
  mmrc_rsp_if.source out_ch,
  mmrc_cfg_if.sink   cfg_ch
);
  import mmrc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_ISSUE, S_RD_WAIT, S_SCAN_ISSUE, S_SCAN_WAIT, S_SCAN_EVAL,
    S_SUM_ISSUE, S_SUM_WAIT, S_SUM_EVAL, S_SH_ISSUE, S_SH_WAIT, S_SH_PUT,
    S_DONE
  } state_t;

  state_t          state_r;
  req_t            req_r;
  rsp_t            rsp_r;
  logic            out_valid_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   idx_r;
  logic [CW-1:0]   pos_r;
  logic [15:0]     usable_r;
  logic [1:0]      pend_r;    // inserts still to do: bit1 region, bit0 tail
  entry_t          ins_r;
  entry_t          tail_r;
  logic [63:0]     sum_lo_r;
  logic [63:0]     sum_up_r;

  // ram port
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  entry_t          ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t          rd_e;

  assign rd_e = entry_t'(ram_rdata);

  mmrc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = rsp_r;

  // 65-bit tops for scan compare
  logic [64:0] rtop, etop;
  logic        fits, tail, split;
  logic [1:0]  need;
  assign rtop   = {1'b0, req_r.region_base} + {1'b0, req_r.region_length};
  assign etop   = {1'b0, rd_e.base} + {1'b0, rd_e.length};
  assign fits   = (rtop <= etop) && (req_r.region_base >= rd_e.base);
  assign tail   = (rtop != etop);
  assign split  = req_r.region_base > rd_e.base;
  assign need   = {1'b0, split} + {1'b0, tail};

  // summarize contribution
  logic [63:0] add_lo, add_up;
  always_comb begin
    add_lo = '0;
    add_up = '0;
    if (rd_e.kind == usable_r) begin
      if (rd_e.base < LOW_LIMIT) begin
        if (etop > {1'b0, LOW_LIMIT}) begin
          add_lo = LOW_LIMIT - rd_e.base;
          add_up = rd_e.length - add_lo;
        end else begin
          add_lo = rd_e.length;
        end
      end else begin
        add_up = rd_e.length;
      end
    end
  end

  // ram address and write mux
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_r[AW-1:0];
    ram_wdata = ins_r;
    case (state_r)
      S_SH_ISSUE, S_SH_WAIT: ram_addr = AW'(idx_r - CW'(1));
      S_SH_PUT: begin
        ram_we   = 1'b1;
        ram_addr = idx_r[AW-1:0];
        ram_wdata = (idx_r == pos_r) ? ins_r : rd_e;
      end
      S_SCAN_EVAL: begin
        ram_addr = idx_r[AW-1:0];
        ram_we   = fits && (count_r + CW'(need) <= CW'(TABLE_DEPTH));
        ram_wdata = rd_e;
        if (split) ram_wdata.length = req_r.region_base - rd_e.base;
        else begin
          ram_wdata.length = req_r.region_length;
          ram_wdata.kind   = req_r.region_type;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rsp_r       <= '0;
      count_r     <= '0;
      usable_r    <= 16'd1;
      pend_r      <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) usable_r <= cfg_ch.data;
      // response taken: clear it for the next beat
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
        rsp_r       <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req_r    <= in_ch.data;
            sum_lo_r <= '0;
            sum_up_r <= '0;
            case (in_ch.data.func)
              FUNC_CLEAR: begin
                count_r <= '0;
                state_r <= S_DONE;
              end
              FUNC_APPEND: begin
                if (count_r >= CW'(TABLE_DEPTH)) begin
                  rsp_r.status <= ST_FULL;
                  state_r      <= S_DONE;
                end else begin
                  ins_r   <= '{in_ch.data.region_base, in_ch.data.region_length,
                               in_ch.data.region_type};
                  pos_r   <= count_r;
                  idx_r   <= count_r;
                  pend_r  <= 2'b00;
                  state_r <= S_SH_PUT;
                end
              end
              FUNC_CARVE: begin
                idx_r   <= '0;
                state_r <= S_SCAN_ISSUE;
              end
              FUNC_READ: begin
                if (32'(in_ch.data.entry_index) >= 32'(count_r)) begin
                  rsp_r.status <= ST_RANGE;
                  state_r      <= S_DONE;
                end else begin
                  idx_r   <= CW'(in_ch.data.entry_index);
                  state_r <= S_RD_ISSUE;
                end
              end
              FUNC_SUM: begin
                idx_r   <= '0;
                state_r <= S_SUM_ISSUE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_RD_ISSUE: state_r <= S_RD_WAIT;
        S_RD_WAIT: begin
          rsp_r.read_base    <= rd_e.base;
          rsp_r.entry_length <= rd_e.length;
          rsp_r.read_kind    <= rd_e.kind;
          state_r            <= S_DONE;
        end
        S_SCAN_ISSUE: begin
          if (idx_r >= count_r) begin
            rsp_r.status <= ST_NO_ENTRY;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: state_r <= S_SCAN_EVAL;
        S_SCAN_EVAL: begin
          if (!fits) begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_SCAN_ISSUE;
          end else if (count_r + CW'(need) > CW'(TABLE_DEPTH)) begin
            rsp_r.status <= ST_FULL;
            state_r      <= S_DONE;
          end else begin
            tail_r <= '{rtop[63:0], etop[63:0] - rtop[63:0], rd_e.kind};
            ins_r  <= split ? '{req_r.region_base, req_r.region_length,
                                req_r.region_type}
                            : '{rtop[63:0], etop[63:0] - rtop[63:0], rd_e.kind};
            pend_r <= {split, split & tail};
            if (split || tail) begin
              pos_r   <= idx_r + CW'(1);
              idx_r   <= count_r;
              state_r <= (count_r == idx_r + CW'(1)) ? S_SH_PUT : S_SH_ISSUE;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        // shift one entry up per pass, then drop in the new one
        S_SH_ISSUE: state_r <= S_SH_WAIT;
        S_SH_WAIT:  state_r <= S_SH_PUT;
        S_SH_PUT: begin
          if (idx_r == pos_r) begin
            count_r <= count_r + CW'(1);
            if (pend_r[0]) begin
              pend_r  <= '0;
              ins_r   <= tail_r;
              pos_r   <= pos_r + CW'(1);
              idx_r   <= count_r + CW'(1);
              state_r <= (count_r == pos_r) ? S_SH_PUT : S_SH_ISSUE;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            idx_r   <= idx_r - CW'(1);
            state_r <= (idx_r - CW'(1) == pos_r) ? S_SH_PUT : S_SH_ISSUE;
          end
        end
        S_SUM_ISSUE: begin
          if (idx_r >= count_r) begin
            rsp_r.lower_total <= sum_lo_r;
            rsp_r.upper_total <= sum_up_r;
            state_r           <= S_DONE;
          end else begin
            state_r <= S_SUM_WAIT;
          end
        end
        S_SUM_WAIT: state_r <= S_SUM_EVAL;
        S_SUM_EVAL: begin
          sum_lo_r <= sum_lo_r + add_lo;
          sum_up_r <= sum_up_r + add_up;
          idx_r    <= idx_r + CW'(1);
          state_r  <= S_SUM_ISSUE;
        end
        S_DONE: begin
          rsp_r.table_count <= 9'(count_r);
          out_valid_r       <= 1'b1;
          state_r           <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
